// ===== rtl/core/mmrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmrd_pkg - shared definitions for the multiset merge repeat detector
// Command codes, controller states, default sizes and the control words that
// pass between the controller, the cell chain and the result stage.
// ----------------------------------------------------------------------------
package mmrd_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 128;
    localparam int VALUE_BITS_DEF = 32;

    // field widths fixed by the interface
    localparam int OP_BITS    = 2;
    localparam int IN_BITS    = 32;
    localparam int OUT_BITS   = 32;
    localparam int LEN_BITS   = 8;
    localparam int SKEW_BITS  = 8;
    localparam int PROD_BITS  = LEN_BITS + SKEW_BITS;
    localparam int WIDE_BITS  = 64;

    // skew ratio after reset
    localparam logic [SKEW_BITS-1:0] SKEW_RESET = 8'd40;

    // command codes carried by the op field
    typedef enum logic [OP_BITS-1:0] {
        OP_BEGIN  = 2'd0,
        OP_ELEM   = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    // chain control: sorted insert of the broadcast value, or shift to head
    typedef struct packed {
        logic insert;
        logic shift;
    } t_chain_ctrl;

    // result stage control: look at the head word, or close the run
    typedef struct packed {
        logic step;
        logic flush;
    } t_emit_ctrl;

endpackage

// ===== rtl/core/mmrd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmrd_cell - one slot of the sorted store
// Holds one value and its valid bit. On insert it keeps its value, takes the
// new word or takes its left neighbour's value; on drain it takes the right
// neighbour's value so the store streams out of cell zero.
// ----------------------------------------------------------------------------
module mmrd_cell #(
    parameter int VALUE_BITS = mmrd_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mmrd_pkg::t_chain_ctrl i_ctrl,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic                  i_prev_keep,
    input  logic                  i_prev_valid,
    input  logic [VALUE_BITS-1:0] i_prev_value,
    input  logic                  i_next_valid,
    input  logic [VALUE_BITS-1:0] i_next_value,
    output logic                  o_keep,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_value
);
    import mmrd_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  w_keep;

    // cell stays put when it holds a value not above the new word
    assign w_keep  = r_valid && (r_value <= i_new_value);
    assign o_keep  = w_keep;
    assign o_valid = r_valid;
    assign o_value = r_value;

    // next contents
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_value = i_next_value;
        end else if (i_ctrl.insert) begin
            n_valid = r_valid || i_prev_valid;
            priority if (w_keep) begin
                n_value = r_value;
            end else if (i_prev_keep) begin
                n_value = i_new_value;
            end else begin
                n_value = i_prev_value;
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // value, no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== rtl/core/mmrd_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmrd_chain - row of store cells
// Wires the cells to their neighbours. The store stays packed and ascending
// from cell zero, which is also the head read out during a drain.
// ----------------------------------------------------------------------------
module mmrd_chain #(
    parameter int CAPACITY   = mmrd_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = mmrd_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mmrd_pkg::t_chain_ctrl i_ctrl,
    input  logic [VALUE_BITS-1:0] i_new_value,
    output logic [CAPACITY-1:0]   o_valid_vec,
    output logic                  o_head_valid,
    output logic [VALUE_BITS-1:0] o_head_value
);
    import mmrd_pkg::*;

    logic [VALUE_BITS-1:0] w_value      [CAPACITY];
    logic [VALUE_BITS-1:0] w_prev_value [CAPACITY];
    logic [VALUE_BITS-1:0] w_next_value [CAPACITY];
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_keep;
    logic [CAPACITY-1:0]   w_prev_keep;
    logic [CAPACITY-1:0]   w_prev_valid;
    logic [CAPACITY-1:0]   w_next_valid;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            // left neighbour, cell zero sees an always-kept full neighbour
            if (g == 0) begin : g_first
                assign w_prev_keep[g]  = 1'b1;
                assign w_prev_valid[g] = 1'b1;
                assign w_prev_value[g] = '0;
            end else begin : g_mid
                assign w_prev_keep[g]  = w_keep[g-1];
                assign w_prev_valid[g] = w_valid[g-1];
                assign w_prev_value[g] = w_value[g-1];
            end

            // right neighbour, the last cell drains in an empty slot
            if (g == CAPACITY - 1) begin : g_last
                assign w_next_valid[g] = 1'b0;
                assign w_next_value[g] = '0;
            end else begin : g_inner
                assign w_next_valid[g] = w_valid[g+1];
                assign w_next_value[g] = w_value[g+1];
            end

            mmrd_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_new_value  (i_new_value),
                .i_prev_keep  (w_prev_keep[g]),
                .i_prev_valid (w_prev_valid[g]),
                .i_prev_value (w_prev_value[g]),
                .i_next_valid (w_next_valid[g]),
                .i_next_value (w_next_value[g]),
                .o_keep       (w_keep[g]),
                .o_valid      (w_valid[g]),
                .o_value      (w_value[g])
            );
        end
    endgenerate

    assign o_valid_vec  = w_valid;
    assign o_head_valid = w_valid[0];
    assign o_head_value = w_value[0];

endmodule

// ===== rtl/core/mmrd_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmrd_emit - repeat finder and result register
// Watches the ascending stream from the head of the store, reports each value
// seen at least twice once, holds one result back so the final one can carry
// the last mark, and drives the output word register.
// ----------------------------------------------------------------------------
module mmrd_emit #(
    parameter int VALUE_BITS = mmrd_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mmrd_pkg::t_emit_ctrl          i_ctrl,
    input  logic [VALUE_BITS-1:0]         i_head_value,
    input  logic                          i_overflow,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mmrd_pkg::OUT_BITS-1:0] o_repeat_value,
    output logic                          o_has_value,
    output logic                          o_last,
    output logic                          o_overflow,
    output logic                          o_slot_free
);
    import mmrd_pkg::*;

    logic                  r_prev_valid;
    logic [VALUE_BITS-1:0] r_prev_value;
    logic                  r_run_hit;
    logic                  r_pend_valid;
    logic [VALUE_BITS-1:0] r_pend_value;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_value;
    logic                  r_out_has;
    logic                  r_out_last;
    logic                  r_out_ovf;
    logic                  w_eq;
    logic                  w_found;
    logic                  w_push;
    logic                  w_push_has;
    logic                  w_push_last;
    logic [WIDE_BITS-1:0]  w_pend_wide;

    // repeat detection on the head word
    assign w_eq    = r_prev_valid && (i_head_value == r_prev_value);
    assign w_found = i_ctrl.step && w_eq && !r_run_hit;

    // a held result goes out when a newer one appears or the run closes
    assign w_push      = (w_found && r_pend_valid) || i_ctrl.flush;
    assign w_push_has  = i_ctrl.flush ? r_pend_valid : 1'b1;
    assign w_push_last = i_ctrl.flush;
    assign w_pend_wide = WIDE_BITS'(r_pend_value);

    assign o_slot_free = !r_out_valid || i_out_ready;

    // control state of the finder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_run_hit    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctrl.flush) begin
                r_prev_valid <= 1'b0;
                r_run_hit    <= 1'b0;
                r_pend_valid <= 1'b0;
            end else if (i_ctrl.step) begin
                r_prev_valid <= 1'b1;
                r_run_hit    <= w_eq;
                if (w_found) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_prev_value <= i_head_value;
        end
        if (w_found) begin
            r_pend_value <= i_head_value;
        end
        if (w_push) begin
            r_out_value <= w_push_has ? w_pend_wide[OUT_BITS-1:0] : '0;
            r_out_has   <= w_push_has;
            r_out_last  <= w_push_last;
            r_out_ovf   <= i_overflow;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_repeat_value = r_out_value;
    assign o_has_value    = r_out_has;
    assign o_last         = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== rtl/core/multiset_merge_repeat_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_merge_repeat_detector - sorted list merge with repeat reporting
// Top level: command decoding, list skew check, run bookkeeping and the
// drain sequence that streams the store through the repeat finder.
// ----------------------------------------------------------------------------
// Begin-list and element words are accepted back to back while idle: every
// cell compares the incoming element with its own value at once and the row
// shifts right by one from the insertion point, so the store is sorted as it
// fills. A finish word drains the row through cell zero, one cell per cycle
// while results are taken without stall; the block accepts no word during
// that drain. Results leave from an output register, and the store is empty
// again when the last one is queued.
module multiset_merge_repeat_detector #(
    parameter int CAPACITY   = mmrd_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = mmrd_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mmrd_pkg::SKEW_BITS-1:0] i_cfg_data,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mmrd_pkg::OP_BITS-1:0]   i_op,
    input  logic [mmrd_pkg::IN_BITS-1:0]   i_value,
    input  logic [mmrd_pkg::LEN_BITS-1:0]  i_list_length,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mmrd_pkg::OUT_BITS-1:0]  o_repeat_value,
    output logic                           o_has_value,
    output logic                           o_last,
    output logic                           o_overflow
);
    import mmrd_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    t_state                r_state;
    t_state                n_state;
    logic [SKEW_BITS-1:0]  r_skew;
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_list_nz;
    logic                  r_skip;
    logic                  r_ovf;
    t_chain_ctrl           w_chain_ctrl;
    t_emit_ctrl            w_emit_ctrl;
    logic [CAPACITY-1:0]   w_valid_vec;
    logic                  w_head_valid;
    logic [VALUE_BITS-1:0] w_head_value;
    logic [VALUE_BITS-1:0] w_new_value;
    logic                  w_slot_free;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_skewed;
    logic [PROD_BITS-1:0]  w_len_prod;
    logic [PROD_BITS-1:0]  w_cnt_prod;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = w_valid_vec[CAPACITY-1];
    assign w_new_value = VALUE_BITS'(WIDE_BITS'(i_value));
    assign o_cfg_ready = 1'b1;

    // skew check of a new list against the merged count
    assign w_len_prod = PROD_BITS'(i_list_length) * PROD_BITS'(r_skew);
    assign w_cnt_prod = PROD_BITS'(r_count) * PROD_BITS'(r_skew);
    assign w_skewed   = (w_len_prod < PROD_BITS'(r_count)) ||
                        (w_cnt_prod < PROD_BITS'(i_list_length));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_op'(i_op) == OP_FINISH)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_slot_free && !w_head_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready   = 1'b0;
        w_chain_ctrl = '0;
        w_emit_ctrl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready          = 1'b1;
                w_chain_ctrl.insert = w_accept && (t_op'(i_op) == OP_ELEM) &&
                                      !r_skip && !w_full;
            end
            ST_DRAIN: begin
                w_chain_ctrl.shift = w_slot_free && w_head_valid;
                w_emit_ctrl.step   = w_slot_free && w_head_valid;
                w_emit_ctrl.flush  = w_slot_free && !w_head_valid;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // state register and skew ratio
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_skew  <= SKEW_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_skew <= i_cfg_data;
            end
        end
    end

    // run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_list_nz <= 1'b0;
            r_skip    <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (w_emit_ctrl.flush) begin
            r_count   <= '0;
            r_list_nz <= 1'b0;
            r_skip    <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (w_accept) begin
            unique case (t_op'(i_op))
                OP_BEGIN: begin
                    r_list_nz <= 1'b1;
                    r_skip    <= r_list_nz ? w_skewed : 1'b0;
                end
                OP_ELEM: begin
                    if (!r_skip) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                    r_skip <= r_skip;
                end
            endcase
        end
    end

    // sorted store
    mmrd_chain #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_chain_ctrl),
        .i_new_value  (w_new_value),
        .o_valid_vec  (w_valid_vec),
        .o_head_valid (w_head_valid),
        .o_head_value (w_head_value)
    );

    // repeat finder and result register
    mmrd_emit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_emit_ctrl),
        .i_head_value   (w_head_value),
        .i_overflow     (r_ovf),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_repeat_value (o_repeat_value),
        .o_has_value    (o_has_value),
        .o_last         (o_last),
        .o_overflow     (o_overflow),
        .o_slot_free    (w_slot_free)
    );

    // merged count matches the filled cells while loading
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(w_valid_vec) == int'(r_count)))
        else $error("merged count differs from filled cells");

    // filled cells stay packed from the head
    a_store_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
        else $error("store not packed from cell zero");

    // the store is empty once a run has closed
    a_store_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_ctrl.flush |=> (w_valid_vec == '0) && (r_state == ST_IDLE))
        else $error("store not cleared after finish");

endmodule
